// ===== rtl/ptc_pkg.sv =====
// shared types and constants for the pressure and temperature compensation pipeline
package ptc_pkg;

    localparam int ADC_W  = 20;
    localparam int CAL_W  = 48;
    localparam int CIDX_W = 2;
    localparam int DVD_W  = 64;
    localparam int DSR_W  = 31;
    localparam int SIDE_W = 34;

    localparam logic signed [32:0] X_OFFSET  = 33'sd128000;
    localparam logic [20:0]        P_BASE    = 21'd1048576;
    localparam logic [11:0]        P_SCALE   = 12'd3125;
    localparam logic [63:0]        DEN_BIAS  = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        TC_MUL    = 32'd5;
    localparam logic [31:0]        TC_ROUND  = 32'd128;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TEMP_CALIB    = 2'd0,
        CFG_PRESS_CALIB_A = 2'd1,
        CFG_PRESS_CALIB_B = 2'd2,
        CFG_PRESS_CALIB_C = 2'd3
    } cfg_index_t;

endpackage

// ===== rtl/ptc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
module ptc_div
    import ptc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DSR_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [DVD_W-1:0]  quotient,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [DVD_W];
    logic [DVD_W-1:0]  dvd_reg  [DVD_W];
    logic [DSR_W-1:0]  rem_reg  [DVD_W];
    logic [DSR_W-1:0]  dsr_reg  [DVD_W];
    logic [SIDE_W-1:0] side_reg [DVD_W];

    logic              vld_in  [DVD_W];
    logic [DVD_W-1:0]  dvd_in  [DVD_W];
    logic [DSR_W-1:0]  rem_in  [DVD_W];
    logic [DSR_W-1:0]  dsr_in  [DVD_W];
    logic [SIDE_W-1:0] side_in [DVD_W];

    genvar j;
    generate
        for (j = 0; j < DVD_W; j++)
        begin : g_stage
            logic [DSR_W:0] trial;
            logic           ge;
            logic [DSR_W:0] diff;

            if (j == 0)
            begin : g_first
                assign vld_in[j]  = in_valid;
                assign dvd_in[j]  = dividend;
                assign rem_in[j]  = '0;
                assign dsr_in[j]  = divisor;
                assign side_in[j] = side;
            end
            else
            begin : g_next
                assign vld_in[j]  = vld_reg[j-1];
                assign dvd_in[j]  = dvd_reg[j-1];
                assign rem_in[j]  = rem_reg[j-1];
                assign dsr_in[j]  = dsr_reg[j-1];
                assign side_in[j] = side_reg[j-1];
            end

            assign trial = {rem_in[j], dvd_in[j][DVD_W-1]};
            assign ge    = trial >= {1'b0, dsr_in[j]};
            assign diff  = trial - {1'b0, dsr_in[j]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[j] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[j] <= vld_in[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dvd_reg[j]  <= {dvd_in[j][DVD_W-2:0], ge};
                    rem_reg[j]  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
                    dsr_reg[j]  <= dsr_in[j];
                    side_reg[j] <= side_in[j];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DVD_W-1];
    assign quotient  = dvd_reg[DVD_W-1];
    assign out_side  = side_reg[DVD_W-1];

endmodule

// ===== rtl/pressure_temperature_compensation_unit.sv =====
// top level of the pressure and temperature compensation pipeline
//
// input transactions carry one raw temperature and one raw pressure reading;
// each yields exactly one output transaction with the temperature in
// hundredths of a degree, the pressure in Q24.8 pascal and a divide-by-zero
// flag on m_tuser (pressure then reads zero)
// the calibration words are written through the cfg channel, which is always
// ready; write it only while no transaction is in flight
// the datapath is an 80-stage pipeline: 11 stages of temperature and
// pressure polynomial math, a 64-stage divider that retires one quotient bit
// per stage, 5 stages of pressure correction; one transaction is taken
// every cycle while s_tready is high
// a two-entry output buffer holds results while m_tready is low; s_tready
// drops only once the second entry fills, and the whole pipeline then holds
// reset clears all valid bits and the calibration words to zero
module pressure_temperature_compensation_unit
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // adc_temp, adc_press
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // temperature_centi, pressure_q24_8
    output logic        m_tuser,   // press_div_zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [CAL_W-1:0] temp_calib_reg, press_a_reg, press_b_reg, press_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TEMP_CALIB:    temp_calib_reg <= cfg_data;
                CFG_PRESS_CALIB_A: press_a_reg    <= cfg_data;
                CFG_PRESS_CALIB_B: press_b_reg    <= cfg_data;
                CFG_PRESS_CALIB_C: press_c_reg    <= cfg_data;
                default:           temp_calib_reg <= temp_calib_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = $signed(temp_calib_reg[31:16]);
    assign t3 = $signed(temp_calib_reg[47:32]);
    assign p1 = press_a_reg[15:0];
    assign p2 = $signed(press_a_reg[31:16]);
    assign p3 = $signed(press_a_reg[47:32]);
    assign p4 = $signed(press_b_reg[15:0]);
    assign p5 = $signed(press_b_reg[31:16]);
    assign p6 = $signed(press_b_reg[47:32]);
    assign p7 = $signed(press_c_reg[15:0]);
    assign p8 = $signed(press_c_reg[31:16]);
    assign p9 = $signed(press_c_reg[47:32]);

    // output buffer and pipeline advance
    logic        adv;
    logic        fin_valid;
    logic [63:0] fin_data;
    logic        fin_flag;
    logic        push;
    logic        out_valid_reg, skid_valid_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic        out_flag_reg, skid_flag_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign push     = adv && fin_valid;

    // stage valid bits
    logic [10:0] pre_vld_reg;
    logic [4:0]  post_vld_reg;
    logic        div_out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
        end
        else if (adv)
        begin
            pre_vld_reg  <= {pre_vld_reg[9:0], s_tvalid};
            post_vld_reg <= {post_vld_reg[3:0], div_out_valid};
        end
    end

    // temperature stages
    logic [ADC_W-1:0] at_reg;
    logic [ADC_W-1:0] ap_reg [8];
    logic [31:0]      tap_reg, tdsq_reg, ta_reg, tbp_reg, fine_reg;
    logic [31:0]      tc_pre_reg [7];

    logic        [17:0] a1;
    logic        [16:0] td;
    logic signed [33:0] tap_full, tdsq_full;
    logic        [31:0] ta_c, tdsq_sh;
    logic signed [47:0] tbp_full;
    logic        [31:0] tb_c, tc_m, tc_c;

    assign a1        = {1'b0, at_reg[19:3]} - {1'b0, t1, 1'b0};
    assign td        = {1'b0, at_reg[19:4]} - {1'b0, t1};
    assign tap_full  = $signed(a1) * t2;
    assign tdsq_full = $signed(td) * $signed(td);
    assign ta_c      = $signed(tap_reg) >>> 11;
    assign tdsq_sh   = $signed(tdsq_reg) >>> 12;
    assign tbp_full  = $signed(tdsq_sh) * t3;
    assign tb_c      = $signed(tbp_reg) >>> 14;
    assign tc_m      = fine_reg * TC_MUL + TC_ROUND;
    assign tc_c      = $signed(tc_m) >>> 8;

    // pressure stages before the divider
    logic signed [32:0] x_reg;
    logic        [63:0] xx_reg, xxp6_reg, xxp3_reg, y_reg, dsum_reg;
    logic        [48:0] xp5_reg, xp2_reg, xp5_b_reg, xp2_b_reg;
    logic        [63:0] dp_reg, num0_reg, num_reg, ma_reg;
    logic        [30:0] den_reg, mb_reg;
    logic               neg_reg, dz_reg;

    logic signed [32:0] x_c;
    logic signed [65:0] xx_full;
    logic signed [48:0] xp5_full, xp2_full;
    logic signed [79:0] xxp6_full, xxp3_full;
    logic        [63:0] xp5_ext, xp2_ext, p4_ext, xxp3_sh, y_c, dsum_c;
    logic        [79:0] dp_full;
    logic        [20:0] pp;
    logic        [63:0] pp_sh;
    logic        [75:0] num_full;

    assign x_c       = $signed({fine_reg[31], fine_reg}) - X_OFFSET;
    assign xx_full   = x_reg * x_reg;
    assign xp5_full  = x_reg * p5;
    assign xp2_full  = x_reg * p2;
    assign xxp6_full = $signed(xx_reg) * p6;
    assign xxp3_full = $signed(xx_reg) * p3;
    assign xp5_ext   = {{15{xp5_b_reg[48]}}, xp5_b_reg} << 17;
    assign xp2_ext   = {{15{xp2_b_reg[48]}}, xp2_b_reg} << 12;
    assign p4_ext    = {{48{p4[15]}}, p4} << 35;
    assign xxp3_sh   = $signed(xxp3_reg) >>> 8;
    assign y_c       = xxp6_reg + xp5_ext + p4_ext;
    assign dsum_c    = xxp3_sh + xp2_ext + DEN_BIAS;
    assign dp_full   = dsum_reg * p1;
    assign pp        = P_BASE - {1'b0, ap_reg[7]};
    assign pp_sh     = {43'd0, pp} << 31;
    assign num_full  = num0_reg * P_SCALE;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            at_reg        <= s_tdata[19:0];
            ap_reg[0]     <= s_tdata[39:20];
            for (int k = 1; k < 8; k++)
            begin
                ap_reg[k] <= ap_reg[k-1];
            end
            tap_reg       <= tap_full[31:0];
            tdsq_reg      <= tdsq_full[31:0];
            ta_reg        <= ta_c;
            tbp_reg       <= tbp_full[31:0];
            fine_reg      <= ta_reg + tb_c;
            x_reg         <= x_c;
            tc_pre_reg[0] <= tc_c;
            for (int k = 1; k < 7; k++)
            begin
                tc_pre_reg[k] <= tc_pre_reg[k-1];
            end
            xx_reg        <= xx_full[63:0];
            xp5_reg       <= xp5_full;
            xp2_reg       <= xp2_full;
            xxp6_reg      <= xxp6_full[63:0];
            xxp3_reg      <= xxp3_full[63:0];
            xp5_b_reg     <= xp5_reg;
            xp2_b_reg     <= xp2_reg;
            y_reg         <= y_c;
            dsum_reg      <= dsum_c;
            dp_reg        <= dp_full[63:0];
            num0_reg      <= pp_sh - y_reg;
            den_reg       <= dp_reg[63:33];
            num_reg       <= num_full[63:0];
            ma_reg        <= num_reg[63] ? (64'd0 - num_reg) : num_reg;
            mb_reg        <= den_reg[30] ? (31'd0 - den_reg) : den_reg;
            neg_reg       <= num_reg[63] ^ den_reg[30];
            dz_reg        <= den_reg == 31'd0;
        end
    end

    // divider
    logic [DVD_W-1:0]  quot;
    logic [SIDE_W-1:0] div_side;

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pre_vld_reg[10]),
        .dividend  (ma_reg),
        .divisor   (mb_reg),
        .side      ({dz_reg, tc_pre_reg[6], neg_reg}),
        .out_valid (div_out_valid),
        .quotient  (quot),
        .out_side  (div_side)
    );

    // pressure correction stages
    logic [63:0] p_reg [4];
    logic [31:0] tc_post_reg [5];
    logic        dz_post_reg [5];
    logic [63:0] s_reg, ps9_reg, p8p_reg, p8p_b_reg, ll_reg, q9_reg, q8_reg;
    logic [31:0] lh_reg, hl_reg, press_reg;

    logic [63:0] s_c, ll_full, lh_full, hl_full, prod_c, q9_c, q8_c, sum_c, r_sh, r_c;
    logic [63:0] p7_ext;
    logic signed [79:0] ps9_full, p8p_full;

    assign s_c      = $signed(p_reg[0]) >>> 13;
    assign ps9_full = $signed(s_c) * p9;
    assign p8p_full = $signed(p_reg[0]) * p8;
    assign ll_full  = {32'd0, ps9_reg[31:0]} * {32'd0, s_reg[31:0]};
    assign lh_full  = {32'd0, ps9_reg[31:0]} * {32'd0, s_reg[63:32]};
    assign hl_full  = {32'd0, ps9_reg[63:32]} * {32'd0, s_reg[31:0]};
    assign prod_c   = ll_reg + {lh_reg + hl_reg, 32'd0};
    assign q9_c     = $signed(prod_c) >>> 25;
    assign q8_c     = $signed(p8p_b_reg) >>> 19;
    assign sum_c    = p_reg[3] + q9_reg + q8_reg;
    assign r_sh     = $signed(sum_c) >>> 8;
    assign p7_ext   = {{48{p7[15]}}, p7} << 4;
    assign r_c      = r_sh + p7_ext;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0]       <= div_side[0] ? (64'd0 - quot) : quot;
            tc_post_reg[0] <= div_side[32:1];
            dz_post_reg[0] <= div_side[33];
            for (int k = 1; k < 4; k++)
            begin
                p_reg[k] <= p_reg[k-1];
            end
            for (int k = 1; k < 5; k++)
            begin
                tc_post_reg[k] <= tc_post_reg[k-1];
                dz_post_reg[k] <= dz_post_reg[k-1];
            end
            s_reg     <= s_c;
            ps9_reg   <= ps9_full[63:0];
            p8p_reg   <= p8p_full[63:0];
            ll_reg    <= ll_full;
            lh_reg    <= lh_full[31:0];
            hl_reg    <= hl_full[31:0];
            p8p_b_reg <= p8p_reg;
            q9_reg    <= q9_c;
            q8_reg    <= q8_c;
            press_reg <= dz_post_reg[3] ? 32'd0 : r_c[31:0];
        end
    end

    assign fin_valid = post_vld_reg[4];
    assign fin_data  = {press_reg, tc_post_reg[4]};
    assign fin_flag  = dz_post_reg[4];

    // two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (out_valid_reg && m_tready)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= push;
            end
            else
            begin
                skid_valid_reg <= skid_valid_reg | push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_flag_reg <= skid_flag_reg;
            end
            else
            begin
                out_data_reg <= fin_data;
                out_flag_reg <= fin_flag;
            end
        end
        else if (!out_valid_reg)
        begin
            out_data_reg <= fin_data;
            out_flag_reg <= fin_flag;
        end
        else
        begin
            if (push)
            begin
                skid_data_reg <= fin_data;
                skid_flag_reg <= fin_flag;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

// ===== tb/ptc_result_checker.sv =====
// checker that predicts compensated readings and compares them with the output stream
module ptc_result_checker
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          fails,
    output int          pending,
    output int          checked,
    output int          div_zero_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic        div_zero;
    } reading_t;

    logic [CAL_W-1:0] calib [4];
    reading_t         expected_readings [$];

    function automatic logic [63:0] sx16(input logic [15:0] w);
        sx16 = {{48{w[15]}}, w};
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] v, input int s);
        sra32 = $signed(v) >>> s;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] v, input int s);
        sra64 = $signed(v) >>> s;
    endfunction

    function automatic reading_t compensate(input logic [19:0] at, input logic [19:0] ap);
        reading_t    r;
        logic [31:0] t1, t2, t3, ta, tb, td, fine, tmp;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] x, y, den, p, num, ma, mb, q, q9, q8, ps;
        t1 = {16'b0, calib[CFG_TEMP_CALIB][15:0]};
        t2 = 32'(sx16(calib[CFG_TEMP_CALIB][31:16]));
        t3 = 32'(sx16(calib[CFG_TEMP_CALIB][47:32]));
        p1 = {48'b0, calib[CFG_PRESS_CALIB_A][15:0]};
        p2 = sx16(calib[CFG_PRESS_CALIB_A][31:16]);
        p3 = sx16(calib[CFG_PRESS_CALIB_A][47:32]);
        p4 = sx16(calib[CFG_PRESS_CALIB_B][15:0]);
        p5 = sx16(calib[CFG_PRESS_CALIB_B][31:16]);
        p6 = sx16(calib[CFG_PRESS_CALIB_B][47:32]);
        p7 = sx16(calib[CFG_PRESS_CALIB_C][15:0]);
        p8 = sx16(calib[CFG_PRESS_CALIB_C][31:16]);
        p9 = sx16(calib[CFG_PRESS_CALIB_C][47:32]);

        ta = ({12'b0, at} >> 3) - (t1 << 1);
        ta = ta * t2;
        ta = sra32(ta, 11);
        td = ({12'b0, at} >> 4) - t1;
        tmp = td * td;
        tmp = sra32(tmp, 12);
        tmp = tmp * t3;
        tb = sra32(tmp, 14);
        fine = ta + tb;
        tmp = fine * 32'd5 + 32'd128;
        r.temp_centi = sra32(tmp, 8);

        x = {{32{fine[31]}}, fine} - 64'd128000;
        y = x * x * p6;
        y = y + ((x * p5) << 17);
        y = y + (p4 << 35);
        den = sra64(x * x * p3, 8) + ((x * p2) << 12);
        den = sra64((64'h0000_8000_0000_0000 + den) * p1, 33);
        r.press_q24_8 = '0;
        r.div_zero = 1'b0;
        if (den == 64'd0)
        begin
            r.div_zero = 1'b1;
        end
        else
        begin
            p = 64'd1048576 - {44'b0, ap};
            num = ((p << 31) - y) * 64'd3125;
            ma = num[63] ? -num : num;
            mb = den[63] ? -den : den;
            q = ma / mb;
            p = (num[63] != den[63]) ? -q : q;
            q9 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
            q8 = sra64(p8 * p, 19);
            ps = sra64(p + q9 + q8, 8) + (p7 << 4);
            r.press_q24_8 = ps[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fails++;
    endtask

    assign pending = expected_readings.size();

    initial
    begin
        fails = 0;
        checked = 0;
        div_zero_seen = 0;
        for (int i = 0; i < 4; i++)
        begin
            calib[i] = '0;
        end
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                calib[cfg_index] = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                expected_readings.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("unexpected transaction", m_tdata[31:0], 32'd0);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (m_tuser)
                    begin
                        div_zero_seen++;
                    end
                    if (m_tdata[31:0] !== want.temp_centi)
                    begin
                        report_mismatch("temperature_centi", m_tdata[31:0], want.temp_centi);
                    end
                    if (m_tdata[63:32] !== want.press_q24_8)
                    begin
                        report_mismatch("pressure_q24_8", m_tdata[63:32], want.press_q24_8);
                    end
                    if (m_tuser !== want.div_zero)
                    begin
                        report_mismatch("press_div_zero", {31'b0, m_tuser},
                                        {31'b0, want.div_zero});
                    end
                end
            end
        end
    end

endmodule

// ===== tb/pressure_temperature_compensation_unit_tb.sv =====
// testbench top: stimulus, sink stalls and verdict for the compensation pipeline
module pressure_temperature_compensation_unit_tb;
    import ptc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 300000;
    localparam int N_SETTINGS   = 6;
    localparam int ITEMS_EACH   = 54;
    localparam int LONG_HOLD    = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;

    int fails;
    int pending;
    int checked;
    int div_zero_seen;
    int cycle_count = 0;
    int sent;
    bit quiet;
    bit hold_req;

    logic [47:0] calib_sets [N_SETTINGS][4];

    pressure_temperature_compensation_unit u_dut (.*);

    ptc_result_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random stall bursts, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_calib(input int set);
        cfg_index_t idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= calib_sets[set][i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_reading(input logic [19:0] at, input logic [19:0] ap);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ap, at};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    function automatic logic [19:0] pick_adc();
        case ($urandom_range(0, 7))
            0: pick_adc = 20'h00000;
            1: pick_adc = 20'hFFFFF;
            2: pick_adc = 20'h80000 + 20'($urandom_range(0, 255));
            default: pick_adc = 20'($urandom());
        endcase
    endfunction

    function automatic logic [47:0] rand48();
        rand48 = {16'($urandom()), 32'($urandom())};
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_TEMP_CALIB;
        cfg_data    = '0;
        sent        = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;

        // all zero: divisor is zero throughout
        for (int i = 0; i < 4; i++)
        begin
            calib_sets[0][i] = '0;
        end
        // typical sensor trim
        calib_sets[1][CFG_TEMP_CALIB]    = {16'hFC18, 16'd26435, 16'd27504};
        calib_sets[1][CFG_PRESS_CALIB_A] = {16'd3024, 16'hD643, 16'd36477};
        calib_sets[1][CFG_PRESS_CALIB_B] = {16'hFFF9, 16'd140, 16'd2855};
        calib_sets[1][CFG_PRESS_CALIB_C] = {16'd6000, 16'hC6F8, 16'd15500};
        // all ones, extreme words and a random trim
        for (int i = 0; i < 4; i++)
        begin
            calib_sets[2][i] = 48'hFFFF_FFFF_FFFF;
            calib_sets[3][i] = 48'h8000_8000_8000;
            calib_sets[4][i] = 48'h7FFF_7FFF_7FFF;
            calib_sets[5][i] = rand48();
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, with the corner readings
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);

        for (int set = 0; set < N_SETTINGS; set++)
        begin
            s_tvalid <= 1'b0;
            while (pending != 0) @(posedge clk);
            write_calib(set);
            if (set == N_SETTINGS - 1)
            begin
                quiet = 1'b1;
            end
            if (set == 1)
            begin
                send_reading(20'd519888, 20'd415148);
                send_reading(20'h00000, 20'h00000);
                send_reading(20'hFFFFF, 20'hFFFFF);
                send_reading(20'h00000, 20'hFFFFF);
                send_reading(20'hFFFFF, 20'h00000);
                send_reading(20'h55555, 20'hAAAAA);
                send_reading(20'hAAAAA, 20'h55555);
                hold_req = 1'b1;
                for (int k = 0; k < 120; k++)
                begin
                    send_reading(20'd500000 + 20'($urandom_range(0, 40000)), pick_adc());
                end
            end
            for (int k = 0; k < ITEMS_EACH; k++)
            begin
                send_reading(pick_adc(), pick_adc());
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("covered %0d readings over %0d calibration settings, %0d results checked",
                 sent, N_SETTINGS + 1, checked);
        $display("zero-divisor results: %0d, output hold-off of %0d cycles included",
                 div_zero_seen, LONG_HOLD);
        if (fails == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== pressure_temperature_compensation_unit.f =====
rtl/ptc_pkg.sv
rtl/ptc_div.sv
rtl/pressure_temperature_compensation_unit.sv
tb/ptc_result_checker.sv
tb/pressure_temperature_compensation_unit_tb.sv
